### rtl/s2lab_pkg.sv
// Shared types, fixed-point constants and the sRGB linearization table
// for the sRGB to CIELAB converter. No dependencies.
package s2lab_pkg;

  localparam int Q         = 24;   // Q24 fraction bits of linear values and ratios
  localparam int LIN_W     = 25;   // linear channel, up to exactly 1.0
  localparam int T_W       = 25;   // XYZ ratio over white, slightly above 1.0
  localparam int F_W       = 25;   // f(t) values
  localparam int COEF_W    = 20;   // Q20 matrix coefficients
  localparam int COEF_Q    = 20;
  localparam int ROOT_W    = 25;   // cube root search bits
  localparam int X_W       = 31;   // 7787 t + 500 on the linear segment
  localparam int QUO_W     = 22;   // (7787 t + 500) / 1000
  localparam int RECIP_SH  = 41;
  localparam logic [31:0] RECIP_M = 32'd2199023256;  // ceil(2^41 / 1000)

  localparam int FRAC_BITS_DEF = 8;
  localparam int FRAC_BITS_MIN = 4;
  localparam int FRAC_BITS_MAX = 12;

  localparam logic [T_W-1:0] KNEE_Q24 =
    T_W'((64'd8856 * 64'd33554432 + 64'd1000000) / 64'd2000000);
  localparam logic [F_W-1:0] OFFS_Q24 = F_W'((64'd268435456 + 64'd58) / 64'd116);

  // sRGB matrix rows divided by the D65 white, Q20
  localparam logic [COEF_W-1:0] MAT_Q20 [3][3] = '{
    '{COEF_W'(((64'd41240 << 21) + 64'd95047) / (64'd2 * 64'd95047)),
      COEF_W'(((64'd35760 << 21) + 64'd95047) / (64'd2 * 64'd95047)),
      COEF_W'(((64'd18050 << 21) + 64'd95047) / (64'd2 * 64'd95047))},
    '{COEF_W'(((64'd2126 << 21) + 64'd10000) / (64'd2 * 64'd10000)),
      COEF_W'(((64'd7152 << 21) + 64'd10000) / (64'd2 * 64'd10000)),
      COEF_W'(((64'd722 << 21) + 64'd10000) / (64'd2 * 64'd10000))},
    '{COEF_W'(((64'd1930 << 21) + 64'd108883) / (64'd2 * 64'd108883)),
      COEF_W'(((64'd11920 << 21) + 64'd108883) / (64'd2 * 64'd108883)),
      COEF_W'(((64'd95050 << 21) + 64'd108883) / (64'd2 * 64'd108883))}
  };

  typedef logic [2:0][T_W-1:0] trip_t;

  typedef struct packed {
    logic [14:0]        lightness;
    logic signed [15:0] green_red_axis;
    logic signed [15:0] blue_yellow_axis;
  } lab_t;

  typedef logic [255:0][LIN_W-1:0] lin_tab_t;

  // r^5 in Q24 with truncation after each product
  function automatic longint unsigned pow5(input longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> 24;
    end
    return p;
  endfunction

  // sRGB transfer curve for one 8-bit code, Q24
  function automatic longint unsigned lin_entry(input longint unsigned v);
    longint unsigned t, t2, r, c;
    r = 0;
    if (v <= 10) begin
      return (v * 5 * 33554432 + 16473) / 32946;
    end
    t  = ((1000 * v + 14025) * 33554432 + 269025) / 538050;
    t2 = (t * t + 8388608) >> 24;
    for (int b = 24; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c <= 16777216 && pow5(c) <= t2) begin
        r = c;
      end
    end
    return (t2 * r + 8388608) >> 24;
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int v = 0; v < 256; v++) begin
      tab[v] = LIN_W'(lin_entry(longint'(v)));
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

### rtl/s2lab_xyz.sv
// Linearization lookup and 3x3 matrix stages: pixel to X/Xn, Y/Yn, Z/Zn in Q24.
// Depends on s2lab_pkg.
module s2lab_xyz (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic              out_valid,
  output s2lab_pkg::trip_t  t_out
);
  import s2lab_pkg::*;

  localparam int PROD_W = COEF_W + LIN_W;
  localparam int SUM_W  = PROD_W + 2;

  logic [LIN_W-1:0]  lin [3];
  logic [PROD_W-1:0] prod [3][3];
  logic              v1, v2;
  logic [SUM_W-1:0]  sum [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SUM_W'(prod[i][0]) + SUM_W'(prod[i][1]) + SUM_W'(prod[i][2])
             + (SUM_W'(1) << (COEF_Q - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      lin[0] <= LIN_TAB[red];
      lin[1] <= LIN_TAB[green];
      lin[2] <= LIN_TAB[blue];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PROD_W'(MAT_Q20[i][j]) * PROD_W'(lin[j]);
        end
        t_out[i] <= sum[i][COEF_Q +: T_W];
      end
    end
  end

endmodule

### rtl/s2lab_cbrt.sv
// Pipelined f(t) for three lanes: bitwise cube root search, two stages per
// root bit, with the linear segment below the knee. Depends on s2lab_pkg.
module s2lab_cbrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  s2lab_pkg::trip_t  t_in,
  output logic              out_valid,
  output s2lab_pkg::trip_t  f_out
);
  import s2lab_pkg::*;

  localparam int SQ_W = 2 * F_W;
  localparam int PR_W = SQ_W + 1;

  typedef struct packed {
    logic [T_W-1:0]   t;
    logic [F_W-1:0]   r;
    logic [SQ_W-1:0]  r2;    // r * r, exact
    logic [QUO_W-1:0] quo;
    logic             above;
  } lane_t;

  logic             p1_valid;
  logic [T_W-1:0]   p1_t [3];
  logic [X_W-1:0]   p1_x [3];
  logic             p1_above [3];

  lane_t            chain [ROOT_W+1][3];
  logic             chain_v [ROOT_W+1];
  lane_t            mid [ROOT_W][3];
  logic [SQ_W-1:0]  mid_sq [ROOT_W][3];
  logic             mid_v [ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid   <= 1'b0;
      chain_v[0] <= 1'b0;
    end else if (ce) begin
      p1_valid   <= in_valid;
      chain_v[0] <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int l = 0; l < 3; l++) begin
        p1_t[l]     <= t_in[l];
        p1_x[l]     <= X_W'(32'(t_in[l]) * 32'd7787 + 32'd500);
        p1_above[l] <= t_in[l] > KNEE_Q24;
        chain[0][l].t     <= p1_t[l];
        chain[0][l].r     <= '0;
        chain[0][l].r2    <= '0;
        chain[0][l].quo   <= QUO_W'((64'(p1_x[l]) * 64'(RECIP_M)) >> RECIP_SH);
        chain[0][l].above <= p1_above[l];
      end
    end
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    localparam int K = ROOT_W - 1 - i;

    logic [F_W-1:0]  cand [3];
    logic [PR_W-1:0] cube [3];
    logic            hit  [3];
    lane_t           lane_next [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        cand[l] = mid[i][l].r | (F_W'(1) << K);
        cube[l] = PR_W'(mid_sq[i][l][SQ_W-1:Q]) * PR_W'(cand[l]);
        hit[l]  = cube[l][PR_W-1:Q] <= (PR_W-Q)'(mid[i][l].t);
        lane_next[l] = mid[i][l];
        if (hit[l]) begin
          lane_next[l].r  = cand[l];
          lane_next[l].r2 = mid_sq[i][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        mid_v[i]     <= 1'b0;
        chain_v[i+1] <= 1'b0;
      end else if (ce) begin
        mid_v[i]     <= chain_v[i];
        chain_v[i+1] <= mid_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        for (int l = 0; l < 3; l++) begin
          // (r + 2^K)^2 = r^2 + r * 2^(K+1) + 2^(2K)
          mid[i][l]    <= chain[i][l];
          mid_sq[i][l] <= chain[i][l].r2 + (SQ_W'(chain[i][l].r) << (K + 1))
                        + (SQ_W'(1) << (2 * K));
          chain[i+1][l] <= lane_next[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= chain_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int l = 0; l < 3; l++) begin
        f_out[l] <= chain[ROOT_W][l].above ? chain[ROOT_W][l].r
                  : F_W'(chain[ROOT_W][l].quo) + OFFS_Q24;
      end
    end
  end

endmodule

### rtl/s2lab_lab.sv
// L, a, b forming from f values: differences, scaling with rounding, saturation.
// Depends on s2lab_pkg.
module s2lab_lab #(
  parameter int FRAC_BITS = s2lab_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  s2lab_pkg::trip_t  f_in,
  output logic              out_valid,
  output s2lab_pkg::lab_t   res
);
  import s2lab_pkg::*;

  localparam int DL_W   = F_W + 9;
  localparam int DF_W   = F_W + 1;
  localparam int PROD_W = 36 + FRAC_BITS;
  localparam int RW     = PROD_W - Q;
  localparam int L_MAX_I = (100 << FRAC_BITS) > 32767 ? 32767 : (100 << FRAC_BITS);

  localparam logic signed [RW-1:0] L_MAX  = RW'(L_MAX_I);
  localparam logic signed [RW-1:0] AB_MAX = RW'(32767);
  localparam logic signed [RW-1:0] AB_MIN = RW'(-32768);
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (Q - 1);

  logic                     v1, v2;
  logic signed [DL_W-1:0]   dl;
  logic signed [DF_W-1:0]   dx, dz;
  logic signed [RW-1:0]     rl, ra, rb;
  logic signed [PROD_W-1:0] pl, pa, pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_comb begin
    pl = ($signed(PROD_W'(dl)) <<< FRAC_BITS) + HALF;
    pa = (($signed(PROD_W'(dx)) * $signed(PROD_W'(500))) <<< FRAC_BITS) + HALF;
    pb = (($signed(PROD_W'(dz)) * $signed(PROD_W'(200))) <<< FRAC_BITS) + HALF;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dl <= $signed(DL_W'(f_in[1]) * DL_W'(116) - (DL_W'(16) << Q));
      dx <= $signed({1'b0, f_in[0]}) - $signed({1'b0, f_in[1]});
      dz <= $signed({1'b0, f_in[1]}) - $signed({1'b0, f_in[2]});

      // floor of (x + half) / 2^24 is the upper slice
      rl <= pl[PROD_W-1:Q];
      ra <= pa[PROD_W-1:Q];
      rb <= pb[PROD_W-1:Q];

      if (rl < 0) begin
        res.lightness <= '0;
      end else if (rl > L_MAX) begin
        res.lightness <= L_MAX[14:0];
      end else begin
        res.lightness <= rl[14:0];
      end
      if (ra > AB_MAX) begin
        res.green_red_axis <= AB_MAX[15:0];
      end else if (ra < AB_MIN) begin
        res.green_red_axis <= AB_MIN[15:0];
      end else begin
        res.green_red_axis <= ra[15:0];
      end
      if (rb > AB_MAX) begin
        res.blue_yellow_axis <= AB_MAX[15:0];
      end else if (rb < AB_MIN) begin
        res.blue_yellow_axis <= AB_MIN[15:0];
      end else begin
        res.blue_yellow_axis <= rb[15:0];
      end
    end
  end

endmodule

### rtl/s2lab_skid.sv
// Output register with a one-beat skid; its pipeline enable depends on flops only.
// Depends on s2lab_pkg.
module s2lab_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  s2lab_pkg::lab_t  in_data,
  output logic             ce,
  output logic             out_valid,
  input  logic             out_ready,
  output s2lab_pkg::lab_t  out_data
);
  import s2lab_pkg::*;

  logic skid_valid;
  lab_t skid_data;

  assign ce = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (ce && in_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (ce && in_valid) begin
        skid_data <= in_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (in_valid) begin
      out_data <= in_data;
    end
  end

endmodule

### rtl/srgb_to_cielab_converter.sv
// sRGB (8 bits per channel) to CIELAB, 2 degree observer, D65 white.
// Pipeline from the accepting edge to m_tvalid: 3 lookup/matrix stages,
// 2 linear-segment stages, 50 cube root stages (two per root bit), 1 select stage,
// 4 output stages. Throughput: one beat per cycle; a stall that parks a beat in the
// skid register holds s_tready low up to and including the cycle it drains.
// Reset (rst, synchronous, active high) clears all valid bits; no clearing pass.
module srgb_to_cielab_converter #(
  parameter int FRAC_BITS = s2lab_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // lightness [14:0], green_red_axis [30:15],
                                 // blue_yellow_axis [46:31], zero [47]
);
  import s2lab_pkg::*;

  // Whole pipeline advances on ce, which drops only while the skid
  // register holds a beat, so input is still taken while a result waits.
  logic  ce;
  logic  xyz_valid, f_valid, lab_valid;
  trip_t t_val, f_val;
  lab_t  lab_res, out_res;

  assign s_tready = ce;

  s2lab_xyz u_xyz (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .red       (s_tdata[7:0]),
    .green     (s_tdata[15:8]),
    .blue      (s_tdata[23:16]),
    .out_valid (xyz_valid),
    .t_out     (t_val)
  );

  // f(t) for X/Xn, Y/Yn, Z/Zn side by side
  s2lab_cbrt u_cbrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (xyz_valid),
    .t_in      (t_val),
    .out_valid (f_valid),
    .f_out     (f_val)
  );

  s2lab_lab #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lab (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (f_valid),
    .f_in      (f_val),
    .out_valid (lab_valid),
    .res       (lab_res)
  );

  s2lab_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lab_valid),
    .in_data   (lab_res),
    .ce        (ce),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {1'b0, out_res.blue_yellow_axis, out_res.green_red_axis,
                    out_res.lightness};

endmodule
